[rtl/core/glob_wildcard_name_match_defines.svh]
// Assertion macros for the glob wildcard name matcher.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef GLOB_WILDCARD_NAME_MATCH_DEFINES_SVH
`define GLOB_WILDCARD_NAME_MATCH_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check with reset masking
`define GWNM_ASSERT(lbl, c, rn, prop, msg) \
  lbl: assert property (@(posedge c) disable iff (!rn) prop) else $error(msg);
// check that also holds across reset
`define GWNM_ASSERT_ALWAYS(lbl, c, prop, msg) \
  lbl: assert property (@(posedge c) prop) else $error(msg);
`else
`define GWNM_ASSERT(lbl, c, rn, prop, msg)
`define GWNM_ASSERT_ALWAYS(lbl, c, prop, msg)
`endif

`endif

[rtl/core/gwnm_pkg.sv]
// Shared constants for the glob wildcard name matcher.
// No dependencies; used by gwnm_stage and glob_wildcard_name_match.
`default_nettype none

package gwnm_pkg;

  localparam int NAME_CHARS_DEF = 20;
  localparam int SRC_CHARS      = 20;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ANY  = 8'h3F;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_MID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RSV     = 2'd3;

  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 16;

endpackage

`default_nettype wire

[rtl/core/glob_wildcard_name_match.sv]
// Glob wildcard name matcher, top level: pattern registers and a chain of gwnm_stage.
// One stage per pattern position; one word per cycle while the output is not stalled.
// Empty stages close up under a stalled output, so input is taken while a result waits.
// Synchronous active-low reset clears all stage valids and the pattern (empty pattern).
// Depends on gwnm_pkg, gwnm_stage and glob_wildcard_name_match_defines.svh.
`default_nettype none
`include "glob_wildcard_name_match_defines.svh"

module glob_wildcard_name_match #(
  parameter int NAME_CHARS = gwnm_pkg::NAME_CHARS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [gwnm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gwnm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // name_bytes_lo[63:0], name_bytes_mid[127:64], name_bytes_hi[159:128], entry_tag[167:160]
  input  wire logic [gwnm_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // matched[0], tag_out[8:1], zero[15:9]
  output logic [gwnm_pkg::OUT_DATA_W-1:0]          out_tdata
);

  localparam int NT = NAME_CHARS + 1;
  localparam int SRC_BITS = 8 * gwnm_pkg::SRC_CHARS;

  logic [63:0] pat_lo_r;
  logic [63:0] pat_mid_r;
  logic [31:0] pat_hi_r;
  logic [SRC_BITS-1:0] pat_src;

  logic [NAME_CHARS:0]     vld_a;
  logic [NAME_CHARS:0]     rdy_a;
  logic [8*NAME_CHARS-1:0] txt_a [0:NAME_CHARS];
  logic [NT-1:0]           end_a [0:NAME_CHARS];
  logic [NT-1:0]           ok_a  [0:NAME_CHARS];
  logic [NT-1:0]           val_a [0:NAME_CHARS];
  logic                    chk_a [0:NAME_CHARS];
  logic [7:0]              tag_a [0:NAME_CHARS];
  logic [NT-1:0]           nul0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_mid_r <= '0;
      pat_hi_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gwnm_pkg::CFG_PAT_LO:  pat_lo_r  <= cfg_wdata;
        gwnm_pkg::CFG_PAT_MID: pat_mid_r <= cfg_wdata;
        gwnm_pkg::CFG_PAT_HI:  pat_hi_r  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign pat_src = {pat_hi_r, pat_mid_r, pat_lo_r};

  // unpack the name; positions past the field bytes read as NUL
  for (genvar k = 0; k < NAME_CHARS; k++) begin : g_txt
    if (k < gwnm_pkg::SRC_CHARS) begin : g_src
      assign txt_a[0][8*k +: 8] = in_tdata[8*k +: 8];
    end else begin : g_pad
      assign txt_a[0][8*k +: 8] = gwnm_pkg::CH_NUL;
    end
    assign nul0[k] = (txt_a[0][8*k +: 8] == gwnm_pkg::CH_NUL);
  end
  assign nul0[NT-1] = 1'b1;

  for (genvar t = 0; t < NT; t++) begin : g_end
    assign end_a[0][t] = |nul0[t:0];
  end

  assign vld_a[0] = in_tvalid;
  assign ok_a[0]  = end_a[0];
  assign val_a[0] = end_a[0];
  assign chk_a[0] = 1'b1;
  assign tag_a[0] = in_tdata[SRC_BITS +: 8];

  // stage s resolves pattern position NAME_CHARS-1-s
  for (genvar s = 0; s < NAME_CHARS; s++) begin : g_stage
    localparam int P = NAME_CHARS - 1 - s;
    logic [7:0] pbyte;
    if (P < gwnm_pkg::SRC_CHARS) begin : g_pb
      assign pbyte = pat_src[8*P +: 8];
    end else begin : g_pz
      assign pbyte = gwnm_pkg::CH_NUL;
    end

    gwnm_stage #(
      .NAME_CHARS(NAME_CHARS)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .pat_byte (pbyte),
      .up_vld   (vld_a[s]),
      .up_rdy   (rdy_a[s]),
      .txt_i    (txt_a[s]),
      .end_i    (end_a[s]),
      .ok_i     (ok_a[s]),
      .val_i    (val_a[s]),
      .chk_i    (chk_a[s]),
      .tag_i    (tag_a[s]),
      .dn_vld   (vld_a[s+1]),
      .dn_rdy   (rdy_a[s+1]),
      .txt_o    (txt_a[s+1]),
      .end_o    (end_a[s+1]),
      .ok_o     (ok_a[s+1]),
      .val_o    (val_a[s+1]),
      .chk_o    (chk_a[s+1]),
      .tag_o    (tag_a[s+1])
    );
  end

  assign rdy_a[NAME_CHARS] = out_tready;
  assign in_tready  = rdy_a[0];
  assign out_tvalid = vld_a[NAME_CHARS];
  assign out_tdata  = {7'b0, tag_a[NAME_CHARS],
                       ok_a[NAME_CHARS][0] & val_a[NAME_CHARS][0]};

  `GWNM_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")
  `GWNM_ASSERT(a_ready_when_drained, clk, rst_n, !out_tvalid |-> in_tready, "input stalled with output empty")
  `GWNM_ASSERT(a_rsv_write_ignored, clk, rst_n, cfg_we && cfg_index == gwnm_pkg::CFG_RSV |=> $stable(pat_lo_r) && $stable(pat_mid_r) && $stable(pat_hi_r), "reserved index wrote pattern")

endmodule

`default_nettype wire

[rtl/core/gwnm_stage.sv]
// One pipeline stage of the glob matcher: resolves one pattern position for all
// text positions from the result vectors of the position after it.
// Depends on gwnm_pkg and glob_wildcard_name_match_defines.svh.
`default_nettype none
`include "glob_wildcard_name_match_defines.svh"

module gwnm_stage #(
  parameter int NAME_CHARS = gwnm_pkg::NAME_CHARS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [7:0]              pat_byte,
  input  wire logic                    up_vld,
  output logic                         up_rdy,
  input  wire logic [8*NAME_CHARS-1:0] txt_i,
  input  wire logic [NAME_CHARS:0]     end_i,
  input  wire logic [NAME_CHARS:0]     ok_i,
  input  wire logic [NAME_CHARS:0]     val_i,
  input  wire logic                    chk_i,
  input  wire logic [7:0]              tag_i,
  output logic                         dn_vld,
  input  wire logic                    dn_rdy,
  output logic [8*NAME_CHARS-1:0]      txt_o,
  output logic [NAME_CHARS:0]          end_o,
  output logic [NAME_CHARS:0]          ok_o,
  output logic [NAME_CHARS:0]          val_o,
  output logic                         chk_o,
  output logic [7:0]                   tag_o
);

  localparam int NT = NAME_CHARS + 1;

  logic                    vld_r;
  logic [8*NAME_CHARS-1:0] txt_r;
  logic [NT-1:0]           end_r;
  logic [NT-1:0]           ok_r;
  logic [NT-1:0]           val_r;
  logic                    chk_r;
  logic [7:0]              tag_r;

  logic [NT-1:0] ok_nxt;
  logic [NT-1:0] val_nxt;
  logic          chk_nxt;
  logic [NT-1:0] gok;
  logic [NT-1:0] gval;
  logic          is_star;
  logic          is_nul;
  logic          is_any;

  assign is_star = (pat_byte == gwnm_pkg::CH_STAR);
  assign is_nul  = (pat_byte == gwnm_pkg::CH_NUL);
  assign is_any  = (pat_byte == gwnm_pkg::CH_ANY);
  assign chk_nxt = is_nul | (is_star & chk_i);

  // first resolved entry at or after each text position
  always_comb begin
    logic [NT-1:0] m;
    logic [NT-1:0] sel;
    for (int t = 0; t < NT; t++) begin
      m       = ok_i & ({NT{1'b1}} << t);
      sel     = m & (~m + {{(NT-1){1'b0}}, 1'b1});
      gok[t]  = |m;
      gval[t] = |(sel & val_i);
    end
  end

  always_comb begin
    for (int t = 0; t < NT - 1; t++) begin
      if (end_i[t]) begin
        ok_nxt[t]  = 1'b1;
        val_nxt[t] = chk_nxt;
      end else if (!is_nul && (is_any || pat_byte == txt_i[8*t +: 8])) begin
        ok_nxt[t]  = ok_i[t+1];
        val_nxt[t] = val_i[t+1];
      end else if (is_star) begin
        ok_nxt[t]  = gok[t];
        val_nxt[t] = gval[t];
      end else begin
        ok_nxt[t]  = 1'b0;
        val_nxt[t] = 1'b0;
      end
    end
    if (end_i[NT-1]) begin
      ok_nxt[NT-1]  = 1'b1;
      val_nxt[NT-1] = chk_nxt;
    end else if (is_star) begin
      ok_nxt[NT-1]  = gok[NT-1];
      val_nxt[NT-1] = gval[NT-1];
    end else begin
      ok_nxt[NT-1]  = 1'b0;
      val_nxt[NT-1] = 1'b0;
    end
  end

  assign up_rdy = !vld_r || dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      txt_r <= txt_i;
      end_r <= end_i;
      ok_r  <= ok_nxt;
      val_r <= val_nxt;
      chk_r <= chk_nxt;
      tag_r <= tag_i;
    end
  end

  assign dn_vld = vld_r;
  assign txt_o  = txt_r;
  assign end_o  = end_r;
  assign ok_o   = ok_r;
  assign val_o  = val_r;
  assign chk_o  = chk_r;
  assign tag_o  = tag_r;

  `GWNM_ASSERT(a_stall_hold, clk, rst_n, vld_r && !dn_rdy |=> vld_r && $stable(tag_r) && $stable(ok_r) && $stable(val_r), "stalled stage changed")
  `GWNM_ASSERT(a_tail_resolved, clk, rst_n, vld_r |-> ok_r[NT-1] && end_r[NT-1], "end of text not resolved")
  `GWNM_ASSERT(a_end_thermo, clk, rst_n, vld_r |-> (end_r[NT-2:0] & ~end_r[NT-1:1]) == '0, "end-of-name vector not a thermometer")

endmodule

`default_nettype wire

[tb/sv/glob_wildcard_name_match_tb.sv]
`timescale 1ns / 1ps
// Testbench for glob_wildcard_name_match: streams padded names under a series of patterns,
// predicts each match flag and tag, and checks every result word in order.
// Depends on gwnm_pkg and the glob_wildcard_name_match RTL only.
module glob_wildcard_name_match_tb;
  import gwnm_pkg::*;

  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 14;
  localparam int PHASE_NAMES = 102;

  typedef struct packed {
    logic       hit;
    logic [7:0] tag;
  } verdict_t;

  class match_board;
    logic [63:0] pat_lo;
    logic [63:0] pat_mid;
    logic [31:0] pat_hi;
    verdict_t    verdicts_due[$];
    int          errors;

    function new();
      pat_lo  = '0;
      pat_mid = '0;
      pat_hi  = '0;
      errors  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_PAT_LO:  pat_lo = v;
        CFG_PAT_MID: pat_mid = v;
        CFG_PAT_HI:  pat_hi = v[31:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] char_at(logic [159:0] s, int k);
      if (k >= SRC_CHARS) return CH_NUL;
      return s[8*k +: 8];
    endfunction

    // greedy scan with one star backtrack point; a star in the pattern that meets a
    // star in the name is taken as a literal first
    function bit pattern_hit(logic [159:0] pat, logic [159:0] nm);
      int  pat_i;
      int  nm_i;
      int  star_pat;
      int  star_nm;
      bit  seen_star;
      pat_i = 0;
      nm_i = 0;
      star_pat = 0;
      star_nm = 0;
      seen_star = 1'b0;
      while (nm_i <= SRC_CHARS && char_at(nm, nm_i) != CH_NUL) begin
        if (pat_i <= SRC_CHARS && char_at(pat, pat_i) != CH_NUL &&
            (char_at(pat, pat_i) == CH_ANY || char_at(pat, pat_i) == char_at(nm, nm_i))) begin
          pat_i++;
          nm_i++;
        end else if (pat_i <= SRC_CHARS && char_at(pat, pat_i) == CH_STAR) begin
          seen_star = 1'b1;
          star_pat = pat_i;
          star_nm = nm_i;
          pat_i++;
        end else if (seen_star) begin
          pat_i = star_pat + 1;
          star_nm++;
          nm_i = star_nm;
        end else begin
          return 1'b0;
        end
      end
      while (pat_i <= SRC_CHARS && char_at(pat, pat_i) == CH_STAR) pat_i++;
      return (pat_i > SRC_CHARS) || (char_at(pat, pat_i) == CH_NUL);
    endfunction

    function void note_name(logic [IN_DATA_W-1:0] w);
      verdict_t v;
      v.hit = pattern_hit({pat_hi, pat_mid, pat_lo}, w[159:0]);
      v.tag = w[167:160];
      verdicts_due.push_back(v);
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] d);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, d);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      if (d[0] !== want.hit) begin
        $display("%0t: matched mismatch, expected %0b, actual %0b", $time, want.hit, d[0]);
        errors++;
      end
      if (d[8:1] !== want.tag) begin
        $display("%0t: tag_out mismatch, expected %h, actual %h", $time, want.tag, d[8:1]);
        errors++;
      end
    endfunction

    function int backlog();
      return verdicts_due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  // name_bytes_lo[63:0], name_bytes_mid[127:64], name_bytes_hi[159:128], entry_tag[167:160]
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // matched[0], tag_out[8:1], zero[15:9]
  logic [OUT_DATA_W-1:0] out_tdata;

  match_board board = new();
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  bit rx_steady = 1'b0;
  int rx_stall  = 0;
  int idle_cycles = 0;

  glob_wildcard_name_match dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return 8'h61 + 8'(r % 3);
    if (r == 14) return CH_STAR;
    if (r == 15) return CH_ANY;
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [159:0] text(string s);
    logic [159:0] v;
    v = '0;
    for (int k = 0; k < s.len() && k < SRC_CHARS; k++) v[8*k +: 8] = s[k];
    return v;
  endfunction

  // terminate at n and leave either zeros or junk behind the terminator
  function automatic logic [159:0] finish_tail(logic [159:0] s, int n);
    bit junk;
    junk = 1'($urandom_range(0, 1));
    if (n < SRC_CHARS) s[8*n +: 8] = CH_NUL;
    for (int k = n + 1; k < SRC_CHARS; k++) s[8*k +: 8] = junk ? 8'($urandom) : CH_NUL;
    return s;
  endfunction

  function automatic logic [159:0] make_pattern(int kind);
    logic [159:0] p;
    int n;
    int r;
    p = '0;
    case (kind)
      0: return finish_tail(p, 0);
      1: return {SRC_CHARS{CH_STAR}};
      2: return {SRC_CHARS{CH_ANY}};
      3: return '1;
      4: begin
        for (int k = 0; k < SRC_CHARS; k++) p[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 2));
        return p;
      end
      default: begin
        n = $urandom_range(0, SRC_CHARS);
        for (int k = 0; k < n; k++) begin
          r = $urandom_range(0, 19);
          p[8*k +: 8] = (r < 4) ? CH_STAR : (r < 8) ? CH_ANY : pick_char();
        end
        return finish_tail(p, n);
      end
    endcase
  endfunction

  // build a name that the pattern should accept, then break it now and then
  function automatic logic [159:0] derive_name(logic [159:0] p);
    logic [159:0] nm;
    logic [7:0]   c;
    int           n;
    int           reps;
    int           at;
    nm = '0;
    n = 0;
    for (int k = 0; k < SRC_CHARS; k++) begin
      c = p[8*k +: 8];
      if (c == CH_NUL) break;
      if (c == CH_STAR) begin
        reps = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 2);
        for (int r = 0; r < reps && n < SRC_CHARS; r++) begin
          nm[8*n +: 8] = pick_char();
          n++;
        end
      end else if (n < SRC_CHARS) begin
        nm[8*n +: 8] = (c == CH_ANY) ? pick_char() : c;
        n++;
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0: if (n > 0) begin
          at = $urandom_range(0, n - 1);
          nm[8*at +: 8] = pick_char();
        end
        1: if (n > 0) n--;
        default: if (n < SRC_CHARS) begin
          nm[8*n +: 8] = pick_char();
          n++;
        end
      endcase
    end
    return finish_tail(nm, n);
  endfunction

  function automatic logic [159:0] noise_name();
    logic [159:0] nm;
    int n;
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom, $urandom, $urandom, $urandom};
    nm = '0;
    n = $urandom_range(0, SRC_CHARS);
    for (int k = 0; k < n; k++) nm[8*k +: 8] = pick_char();
    return finish_tail(nm, n);
  endfunction

  task automatic put_name(logic [159:0] nm, logic [7:0] tag, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {tag, nm};
    do @(posedge clk); while (!in_tready);
    board.note_name(in_tdata);
  endtask

  task automatic drain_names();
    in_tvalid <= 1'b0;
    while (board.backlog() != 0) @(posedge clk);
  endtask

  task automatic cfg_word(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    board.set_reg(idx, v);
  endtask

  task automatic load_pattern(logic [159:0] p, logic [31:0] hi_extra);
    drain_names();
    cfg_we <= 1'b1;
    cfg_word(CFG_RSV, {$urandom, $urandom});
    cfg_word(CFG_PAT_LO, p[63:0]);
    cfg_word(CFG_PAT_MID, p[127:64]);
    cfg_word(CFG_PAT_HI, {hi_extra, p[159:128]});
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty pattern out of reset
    put_name(text(""), 8'h00, 0);
    put_name(text("a"), 8'hFF, gap_len());
    put_name('1, 8'h01, gap_len());

    load_pattern(text("*"), '0);
    put_name(text(""), 8'h02, 0);
    put_name(text("abc"), 8'h03, gap_len());
    put_name('1, 8'h04, gap_len());

    load_pattern({SRC_CHARS{CH_ANY}}, '0);
    put_name(text("abcdefghijabcdefghij"), 8'h05, 0);
    put_name(text("abcdefghijabcdefghi"), 8'h06, gap_len());
    put_name(text(""), 8'h07, gap_len());

    load_pattern(text("a*b?c"), '0);
    put_name(text("axxbyc"), 8'h08, 0);
    put_name(text("abyc"), 8'h09, gap_len());
    put_name(text("ab"), 8'h0A, gap_len());
    put_name(text("a*b?c"), 8'h0B, gap_len());

    // a literal star in the name is matched by the pattern star as a literal, so no backtrack point is set
    load_pattern(text("*a"), '0);
    put_name(text("*ba"), 8'h0C, 0);
    put_name(text("ba"), 8'h0D, gap_len());

    load_pattern(text("a**"), '0);
    put_name(text("a"), 8'h0E, 0);
    put_name(text(""), 8'h0F, gap_len());
    put_name(text("a") | (160'h7A << 40), 8'h10, gap_len());

    load_pattern('1, 32'hFFFF_FFFF);
    put_name('1, 8'h11, 0);
    put_name({CH_NUL, {19{8'hFF}}}, 8'h12, gap_len());

    for (int ph = 0; ph < PHASES; ph++) begin
      logic [159:0] pat;
      pat = make_pattern(ph);
      load_pattern(pat, (ph % 2 == 1) ? 32'($urandom) : 32'h0);
      rx_steady = (ph % 4 == 1);
      if (ph == 5) hold_req = 1'b1;
      for (int i = 0; i < PHASE_NAMES; i++) begin
        put_name(($urandom_range(0, 3) == 0) ? noise_name() : derive_name(pat),
                 8'($urandom_range(0, 255)),
                 ((ph == 5 && i < 60) || ph % 4 == 1) ? 0 : gap_len());
      end
    end

    drain_names();
    repeat (40) @(posedge clk);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) board.check_word(out_tdata);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        rx_stall = HOLD_CYCLES;
      end else if (rx_stall == 0 && !rx_steady && $urandom_range(0, 3) == 0) begin
        rx_stall = gap_len() + 1;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
